// ===== rtl/msd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msd_pkg
// Shared constants, state encoding and status types of the mean and
// standard deviation block.
// ----------------------------------------------------------------------------
package msd_pkg;

	// Default sizing of the block
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 32;

	// Fixed result field widths
	localparam int MEAN_OUT_W  = 40;
	localparam int SD_OUT_W    = 40;
	localparam int COUNT_OUT_W = 11;

	// Fractional bits of the mean and of the deviation
	localparam int FRAC_BITS = 8;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_PASS_GO,
		ST_PASS_WAIT,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_EMIT
	} msd_state_t;

	// Status of a multi-cycle unit
	typedef struct packed {
		logic busy;
		logic done;
	} msd_unit_st_t;

endpackage

`default_nettype wire

// ===== rtl/msd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msd_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module msd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/msd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msd_div
// Restoring unsigned divider, one quotient bit per cycle. Divides a wide
// dividend by a narrow nonzero divisor; the quotient stays valid after done.
// ----------------------------------------------------------------------------
module msd_div import msd_pkg::*; #(
	parameter int DIV_W = 92,
	parameter int DVS_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic      [DIV_W-1:0] quotient,
	output msd_unit_st_t          st
);

	localparam int IT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [IT_W-1:0]  iter_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   rem_sh;
	logic             ge;
	logic [DVS_W:0]   rem_sub;

	// Shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= IT_W'(DIV_W);
			end else if (busy_q) begin
				iter_q <= iter_q - IT_W'(1);
				if (iter_q == IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign st       = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== rtl/msd_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msd_sqrt
// Floor integer square root by digit recurrence, one root bit per cycle.
// ----------------------------------------------------------------------------
module msd_sqrt import msd_pkg::*; #(
	parameter int RAD_W = 92
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RAD_W-1:0]   radicand,
	output logic      [RAD_W/2-1:0] root,
	output msd_unit_st_t            st
);

	localparam int RT_W  = RAD_W / 2;
	localparam int REM_W = RT_W + 3;
	localparam int IT_W  = $clog2(RT_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [IT_W-1:0]  iter_q;
	logic [RAD_W-1:0] rad_q;
	logic [RT_W-1:0]  root_q;
	logic [REM_W-1:0] rem_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	// Bring down two radicand bits, trial subtract 4r+1
	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = REM_W'({root_q, 2'b01});
		ge     = rem_sh >= trial;
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= IT_W'(RT_W);
			end else if (busy_q) begin
				iter_q <= iter_q - IT_W'(1);
				if (iter_q == IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Root and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[RT_W-2:0], ge};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
		end
	end

	assign root = root_q;
	assign st   = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== rtl/msd_sqacc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msd_sqacc
// Second pass over the sample store: reads each held sample, forms its error
// against the mean, squares it from three narrow partial products and sums
// the squares exactly. One sample enters per cycle.
// ----------------------------------------------------------------------------
module msd_sqacc import msd_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [$clog2(MAX_SAMPLES+1)-1:0]       n,
	input  wire logic signed [SAMPLE_BITS+FRAC_BITS:0]  mean,
	output logic      [$clog2(MAX_SAMPLES)-1:0]         rd_addr,
	input  wire logic [SAMPLE_BITS-1:0]                 rd_data,
	output logic [2*(SAMPLE_BITS+FRAC_BITS)+$clog2(MAX_SAMPLES+1)
		+($clog2(MAX_SAMPLES+1)%2)-1:0]                 acc,
	output msd_unit_st_t                                st
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int ERR_W  = SAMPLE_BITS + FRAC_BITS + 1;
	localparam int EM_W   = SAMPLE_BITS + FRAC_BITS;
	localparam int SQ_W   = 2 * EM_W;
	localparam int ACC_W  = SQ_W + CNT_W + (CNT_W % 2);
	localparam int LO_W   = (EM_W + 1) / 2;
	localparam int HI_W   = EM_W - LO_W;

	logic              busy_q;
	logic              issue_q;
	logic              done_q;
	logic [CNT_W-1:0]  idx_q;
	logic              v_s1, v_s2, v_s3, v_s4;

	logic signed [ERR_W-1:0] x_ext;
	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        err_mag;

	logic [EM_W-1:0]         em_s2;
	logic [2*LO_W-1:0]       pp_ll_s3;
	logic [LO_W+HI_W-1:0]    pp_lh_s3;
	logic [2*HI_W-1:0]       pp_hh_s3;
	logic [SQ_W-1:0]         sq_s4;
	logic [ACC_W-1:0]        acc_q;

	// Issue reads, track pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue_q;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			if (start) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				idx_q   <= '0;
			end else if (issue_q) begin
				idx_q <= idx_q + CNT_W'(1);
				if (idx_q + CNT_W'(1) == n) begin
					issue_q <= 1'b0;
				end
			end else if (busy_q && !v_s1 && !v_s2 && !v_s3 && !v_s4) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign rd_addr = idx_q[ADDR_W-1:0];

	// Error against the mean, magnitude
	always_comb begin
		x_ext   = {rd_data[SAMPLE_BITS-1], rd_data, {FRAC_BITS{1'b0}}};
		err     = x_ext - mean;
		err_mag = err[ERR_W-1] ? -err : err;
	end

	// Square through partial products, accumulate
	always_ff @(posedge clk) begin
		em_s2    <= err_mag[EM_W-1:0];
		pp_ll_s3 <= em_s2[LO_W-1:0] * em_s2[LO_W-1:0];
		pp_lh_s3 <= em_s2[LO_W-1:0] * em_s2[EM_W-1:LO_W];
		pp_hh_s3 <= em_s2[EM_W-1:LO_W] * em_s2[EM_W-1:LO_W];
		sq_s4    <= (SQ_W'(pp_hh_s3) << (2 * LO_W)) + (SQ_W'(pp_lh_s3) << (LO_W + 1))
			+ SQ_W'(pp_ll_s3);
		if (start) begin
			acc_q <= '0;
		end else if (v_s4) begin
			acc_q <= acc_q + ACC_W'(sq_s4);
		end
	end

	assign acc = acc_q;
	assign st  = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// ===== rtl/mean_and_std_dev.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mean_and_std_dev
// Population mean and standard deviation of a run of signed samples.
//
// Input channel (in_valid/in_ready): one request carries a sample and a last
// flag. Samples are written into the sample RAM and summed, one per cycle
// while in_ready is high; in_ready stays low from the last request to the emit.
// Samples beyond MAX_SAMPLES are dropped and flagged as overflow.
// On the request marked last the block stops taking input and runs the
// closing sequence: mean divide (one quotient bit per cycle), a pass over
// the RAM (one read per cycle), variance divide and square root, DIV_W
// being the divider width: 2*(SAMPLE_BITS+8) plus the count width rounded
// up to even (92 at default sizing). One divider serves both divides.
// Output channel (out_valid/out_ready): the result sits in an output register;
// a new run loads while it waits, and the closing sequence holds its result
// until the register is free. Reset clears count, sum, flag and out_valid;
// the sample RAM needs no clearing since only written entries are read.
// ----------------------------------------------------------------------------
module mean_and_std_dev import msd_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [31:0]     sample,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [MEAN_OUT_W-1:0] mean,
	output logic [SD_OUT_W-1:0]         std_dev,
	output logic [COUNT_OUT_W-1:0]      count,
	output logic                        overflow
);

	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W  = $clog2(MAX_SAMPLES);
	localparam int SUM_W   = SAMPLE_BITS + CNT_W;
	localparam int MEAN_W  = SAMPLE_BITS + FRAC_BITS + 1;
	localparam int EM_W    = SAMPLE_BITS + FRAC_BITS;
	localparam int ACC_W   = 2 * EM_W + CNT_W + (CNT_W % 2);
	localparam int RT_W    = ACC_W / 2;

	msd_state_t state_q, state_nx;

	logic [CNT_W-1:0]         cnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     drop_q;
	logic signed [MEAN_W-1:0] mean_q;

	logic                     out_valid_q;
	logic [MEAN_OUT_W-1:0]    mean_o_q;
	logic [SD_OUT_W-1:0]      sd_o_q;
	logic [COUNT_OUT_W-1:0]   count_o_q;
	logic                     ovf_o_q;

	logic                     in_fire;
	logic                     mean_start;
	logic                     var_start;
	logic                     pass_start;
	logic                     root_start;
	logic                     emit_fire;

	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [SAMPLE_BITS-1:0]   ram_rdata;

	logic [SUM_W-1:0]         sum_mag;
	logic [ACC_W-1:0]         div_dividend;
	logic [ACC_W-1:0]         div_quo;
	logic [ACC_W-1:0]         sq_acc;
	logic [RT_W-1:0]          root;
	msd_unit_st_t             div_st, sq_st, root_st;

	logic [MEAN_W+MEAN_OUT_W-1:0] mean_x;
	logic [RT_W+SD_OUT_W-1:0]     root_x;
	logic [CNT_W+COUNT_OUT_W-1:0] cnt_x;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_LOAD:      if (in_valid && last) state_nx = ST_MEAN_GO;
			ST_MEAN_GO:   state_nx = ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (div_st.done) state_nx = ST_PASS_GO;
			ST_PASS_GO:   state_nx = ST_PASS_WAIT;
			ST_PASS_WAIT: if (sq_st.done) state_nx = ST_VAR_GO;
			ST_VAR_GO:    state_nx = ST_VAR_WAIT;
			ST_VAR_WAIT:  if (div_st.done) state_nx = ST_ROOT_GO;
			ST_ROOT_GO:   state_nx = ST_ROOT_WAIT;
			ST_ROOT_WAIT: if (root_st.done) state_nx = ST_EMIT;
			ST_EMIT:      if (!out_valid_q || out_ready) state_nx = ST_LOAD;
			default:      state_nx = ST_LOAD;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		mean_start = 1'b0;
		var_start  = 1'b0;
		pass_start = 1'b0;
		root_start = 1'b0;
		emit_fire  = 1'b0;
		case (state_q)
			ST_LOAD:    in_ready   = 1'b1;
			ST_MEAN_GO: mean_start = 1'b1;
			ST_PASS_GO: pass_start = 1'b1;
			ST_VAR_GO:  var_start  = 1'b1;
			ST_ROOT_GO: root_start = 1'b1;
			ST_EMIT:    emit_fire  = !out_valid_q || out_ready;
			default:    in_ready   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_fire = in_valid && in_ready;
	assign ram_we  = in_fire && (cnt_q < CNT_W'(MAX_SAMPLES));

	// Count, running sum and drop flag; clear when the result is taken over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			drop_q <= 1'b0;
		end else if (emit_fire) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			drop_q <= 1'b0;
		end else if (in_fire) begin
			if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + {{CNT_W{sample[SAMPLE_BITS-1]}}, sample[SAMPLE_BITS-1:0]};
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	msd_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (sample[SAMPLE_BITS-1:0]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Shared divider: mean first, then variance
	assign sum_mag      = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign div_dividend = mean_start ? ACC_W'({sum_mag, {FRAC_BITS{1'b0}}}) : sq_acc;

	msd_div #(
		.DIV_W (ACC_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mean_start || var_start),
		.dividend (div_dividend),
		.divisor  (cnt_q),
		.quotient (div_quo),
		.st       (div_st)
	);

	// Capture signed mean
	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN_WAIT && div_st.done) begin
			mean_q <= sum_q[SUM_W-1] ? -div_quo[MEAN_W-1:0] : div_quo[MEAN_W-1:0];
		end
	end

	msd_sqacc #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sqacc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pass_start),
		.n       (cnt_q),
		.mean    (mean_q),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.acc     (sq_acc),
		.st      (sq_st)
	);

	msd_sqrt #(
		.RAD_W (ACC_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (div_quo),
		.root     (root),
		.st       (root_st)
	);

	// Fit results to the port widths
	assign mean_x = {{MEAN_OUT_W{mean_q[MEAN_W-1]}}, mean_q};
	assign root_x = {{SD_OUT_W{1'b0}}, root};
	assign cnt_x  = {{COUNT_OUT_W{1'b0}}, cnt_q};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			mean_o_q  <= mean_x[MEAN_OUT_W-1:0];
			sd_o_q    <= root_x[SD_OUT_W-1:0];
			count_o_q <= cnt_x[COUNT_OUT_W-1:0];
			ovf_o_q   <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign mean      = mean_o_q;
	assign std_dev   = sd_o_q;
	assign count     = count_o_q;
	assign overflow  = ovf_o_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count above capacity");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (cnt_q == '0) && !drop_q && out_valid_q)
		else $error("run state not cleared after result");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cnt_q == CNT_W'(MAX_SAMPLES) && state_nx == ST_LOAD) |=> drop_q)
		else $error("sample beyond capacity not flagged");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_MEAN_WAIT || state_q == ST_VAR_WAIT))
		else $error("divider finished outside a divide step");

endmodule

`default_nettype wire
